// ===== hw/rtl/qets_pkg.sv =====
// qets_pkg: types, character codes and helpers for the quoted escaped token splitter
// no dependencies
package qets_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;

  localparam logic KIND_CONTENT = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // one queued result group: optional backslash prefix, then the main beat
  typedef struct packed {
    logic       pfx;
    logic       kind;
    logic       by_end;
    logic [7:0] data;
  } qets_entry_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b inside {[CH_TAB:CH_CR], CH_SPACE});
  endfunction

endpackage

// ===== hw/rtl/quoted_escaped_token_splitter_core.sv =====
// quoted_escaped_token_splitter_core: top level of the token splitter
// depends on qets_pkg, qets_front, qets_fifo, qets_back
//
// usage
//   input beats carry one text byte in in_tdata; in_tuser high marks end of
//   stream (byte ignored). each input beat gives zero, one or two output beats.
//   output beats: out_tdata is the content or terminating byte, out_tuser[0]
//   is 0 for token content and 1 for end of token, out_tuser[1] flags a token
//   ended by end of stream, out_tlast marks the final beat of one input beat.
//   throughput: one input beat per cycle while the queue is not full; an
//   escaped unknown byte gives two output beats from the single output register.
//   a taken input beat is written into the queue, then into the output register.
//   a four-entry queue sits between the classifier and the output stage, so
//   input keeps flowing while an output beat waits; when the receiver stalls
//   the queue fills and in_tready drops once it is full.
//   reset (rst_n low, synchronous) clears the flags, the queue and out_tvalid.
module quoted_escaped_token_splitter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] end_of_stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] result_kind, [1] ended_by_stream_end
  output logic       out_tlast
);
  import qets_pkg::*;

  logic        q_full, q_push, q_pop, q_head_valid;
  qets_entry_t q_entry, q_head;

  qets_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  qets_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head)
  );

  qets_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_entry (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/qets_front.sv =====
// qets_front: accepts input beats, tracks escape/quote/token flags, classifies bytes
// depends on qets_pkg
module qets_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output qets_pkg::qets_entry_t q_entry
);
  import qets_pkg::*;

  logic esc_r, esc_nxt;
  logic quo_r, quo_nxt;
  logic has_r, has_nxt;
  logic accept;
  logic push_c;
  qets_entry_t ent_c;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign q_push    = accept && push_c;
  assign q_entry   = ent_c;

  always_comb begin
    esc_nxt = esc_r;
    quo_nxt = quo_r;
    has_nxt = has_r;
    push_c  = 1'b0;
    ent_c   = '{pfx: 1'b0, kind: KIND_CONTENT, by_end: 1'b0, data: in_tdata};
    if (in_tuser) begin
      push_c       = 1'b1;
      ent_c.kind   = KIND_END;
      ent_c.by_end = 1'b1;
      ent_c.data   = 8'h00;
      esc_nxt      = 1'b0;
      quo_nxt      = 1'b0;
      has_nxt      = 1'b0;
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      has_nxt = 1'b1;
      push_c  = 1'b1;
      if (!is_ws(in_tdata)) begin
        case (in_tdata)
          CH_LC_A: ent_c.data = CH_BEL;
          CH_LC_B: ent_c.data = CH_BS;
          CH_LC_E: ent_c.data = CH_ESC;
          CH_LC_F: ent_c.data = CH_FF;
          CH_LC_N: ent_c.data = CH_LF;
          CH_LC_R: ent_c.data = CH_CR;
          CH_LC_T: ent_c.data = CH_TAB;
          CH_LC_V: ent_c.data = CH_VT;
          CH_BSLASH, CH_APOS, CH_DQUOTE, CH_QMARK: ent_c.data = in_tdata;
          default: ent_c.pfx = 1'b1;
        endcase
      end
    end else if (in_tdata == CH_BSLASH) begin
      esc_nxt = 1'b1;
    end else if (quo_r) begin
      if (in_tdata == CH_DQUOTE) begin
        quo_nxt = 1'b0;
      end else begin
        push_c  = 1'b1;
        has_nxt = 1'b1;
      end
    end else if (in_tdata == CH_DQUOTE) begin
      quo_nxt = 1'b1;
    end else if (is_ws(in_tdata)) begin
      if (has_r) begin
        push_c     = 1'b1;
        ent_c.kind = KIND_END;
        esc_nxt    = 1'b0;
        quo_nxt    = 1'b0;
        has_nxt    = 1'b0;
      end
    end else begin
      push_c  = 1'b1;
      has_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      quo_r <= 1'b0;
      has_r <= 1'b0;
    end else if (accept) begin
      esc_r <= esc_nxt;
      quo_r <= quo_nxt;
      has_r <= has_nxt;
    end
  end

endmodule

// ===== hw/rtl/qets_fifo.sv =====
// qets_fifo: short result-group queue between front and back
// depends on qets_pkg
module qets_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  qets_pkg::qets_entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output qets_pkg::qets_entry_t head_entry
);
  import qets_pkg::*;

  qets_entry_t      mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == QCW'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(do_push) - QCW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/qets_back.sv =====
// qets_back: expands queued result groups into output beats through an output register
// depends on qets_pkg
module qets_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  qets_pkg::qets_entry_t head_entry,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,   // [7:0] out_byte
  output logic [1:0]           out_tuser,   // [0] result_kind, [1] ended_by_stream_end
  output logic                 out_tlast
);
  import qets_pkg::*;

  logic       vld_r, vld_nxt;
  logic       phase_r, phase_nxt;
  logic [7:0] data_r, data_nxt;
  logic [1:0] user_r, user_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !vld_r || out_tready;

  always_comb begin
    vld_nxt   = vld_r;
    phase_nxt = phase_r;
    data_nxt  = data_r;
    user_nxt  = user_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      vld_nxt = head_valid;
      if (head_valid) begin
        if (head_entry.pfx && !phase_r) begin
          // backslash ahead of an unknown escaped byte
          data_nxt  = CH_BSLASH;
          user_nxt  = {1'b0, KIND_CONTENT};
          last_nxt  = 1'b0;
          phase_nxt = 1'b1;
        end else begin
          data_nxt  = head_entry.data;
          user_nxt  = {head_entry.by_end, head_entry.kind};
          last_nxt  = 1'b1;
          phase_nxt = 1'b0;
          pop       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    user_r <= user_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

// ===== hw/rtl/qets_checker.sv =====
// qets_checker: port-level assertions for the token splitter, bound to the top level
// depends on qets_pkg and quoted_escaped_token_splitter_core
module qets_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,   // [7:0] out_byte
  input logic [1:0] out_tuser,   // [0] result_kind, [1] ended_by_stream_end
  input logic       out_tlast
);
  import qets_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output beat changed");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == KIND_END) |-> out_tlast)
    else $error("end of token beat not last");

  a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> (out_tuser[0] == KIND_END) && out_tdata == 8'h00)
    else $error("stream end beat malformed");

  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata == CH_BSLASH && out_tuser == {1'b0, KIND_CONTENT})
    else $error("non-last beat is not a backslash prefix");

endmodule

bind quoted_escaped_token_splitter_core qets_checker u_qets_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== test/quoted_escaped_token_splitter_core_test.sv =====
// quoted_escaped_token_splitter_core_test: self-checking bench for the token splitter core
// depends on qets_pkg and quoted_escaped_token_splitter_core
// drives byte beats with random gaps and predicts every output beat in order
`timescale 1ns / 100ps

module quoted_escaped_token_splitter_core_test;
  import qets_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int ERR_PRINT_MAX = 50;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic       by_end;
    logic       is_last;
  } token_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b1;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  token_beat_t pending_beats[$];
  logic escape_seen = 1'b0;
  logic quote_open = 1'b0;
  logic token_started = 1'b0;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_request = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  quoted_escaped_token_splitter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic void push_token_beat(input logic kind, input logic [7:0] data,
                                          input logic by_end);
    token_beat_t t;
    t.kind = kind;
    t.data = data;
    t.by_end = by_end;
    t.is_last = 1'b0;
    pending_beats.push_back(t);
  endfunction

  function automatic void clear_token_state();
    escape_seen = 1'b0;
    quote_open = 1'b0;
    token_started = 1'b0;
  endfunction

  // expected output beats for one accepted input beat
  function automatic void predict_split(input logic [7:0] b, input logic eos);
    int n_before;
    logic [7:0] mapped;
    n_before = pending_beats.size();
    mapped = b;
    if (eos) begin
      push_token_beat(KIND_END, 8'h00, 1'b1);
      clear_token_state();
    end else if (escape_seen) begin
      escape_seen = 1'b0;
      if (!is_space(b)) begin
        case (b)
          CH_LC_A: mapped = CH_BEL;
          CH_LC_B: mapped = CH_BS;
          CH_LC_E: mapped = CH_ESC;
          CH_LC_F: mapped = CH_FF;
          CH_LC_N: mapped = CH_LF;
          CH_LC_R: mapped = CH_CR;
          CH_LC_T: mapped = CH_TAB;
          CH_LC_V: mapped = CH_VT;
          CH_BSLASH, CH_DQUOTE, CH_APOS, CH_QMARK: mapped = b;
          default: push_token_beat(KIND_CONTENT, CH_BSLASH, 1'b0);
        endcase
      end
      push_token_beat(KIND_CONTENT, mapped, 1'b0);
      token_started = 1'b1;
    end else if (b == CH_BSLASH) begin
      escape_seen = 1'b1;
    end else if (quote_open) begin
      if (b == CH_DQUOTE) begin
        quote_open = 1'b0;
      end else begin
        push_token_beat(KIND_CONTENT, b, 1'b0);
        token_started = 1'b1;
      end
    end else if (b == CH_DQUOTE) begin
      quote_open = 1'b1;
    end else if (is_space(b)) begin
      if (token_started) begin
        push_token_beat(KIND_END, b, 1'b0);
        clear_token_state();
      end
    end else begin
      push_token_beat(KIND_CONTENT, b, 1'b0);
      token_started = 1'b1;
    end
    if (pending_beats.size() > n_before)
      pending_beats[pending_beats.size() - 1].is_last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < ERR_PRINT_MAX)
      $display("mismatch %s: got %h want %h at beat %0d", what, got, want, beats_checked);
    mismatches++;
  endtask

  task automatic send_item(input logic [7:0] b, input logic eos);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= eos;
    do @(posedge clk); while (!in_tready);
    predict_split(b, eos);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_space();
    int r;
    r = $urandom_range(0, 5);
    return (r < 5) ? CH_TAB + 8'(r) : CH_SPACE;
  endfunction

  function automatic logic [7:0] pick_escaped();
    int r;
    r = $urandom_range(0, 5);
    if (r < 2) begin
      case ($urandom_range(0, 7))
        0: return CH_LC_A;
        1: return CH_LC_B;
        2: return CH_LC_E;
        3: return CH_LC_F;
        4: return CH_LC_N;
        5: return CH_LC_R;
        6: return CH_LC_T;
        default: return CH_LC_V;
      endcase
    end else if (r == 2) begin
      case ($urandom_range(0, 3))
        0: return CH_BSLASH;
        1: return CH_DQUOTE;
        2: return CH_APOS;
        default: return CH_QMARK;
      endcase
    end else if (r == 3) begin
      return pick_space();
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_directed();
    send_text(" \t");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_LC_N, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(8'h78, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_SPACE, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    // quoted run with escape and tab
    send_item(CH_DQUOTE, 1'b0);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_QMARK, 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    send_item(CH_CR, 1'b0);
    // empty quotes leave the token empty
    send_item(CH_DQUOTE, 1'b0);
    send_item(CH_DQUOTE, 1'b0);
    send_item(CH_LF, 1'b0);
    // bytes just outside the whitespace range, then VT inside it
    send_item(CH_BS, 1'b0);
    send_item(8'h0E, 1'b0);
    send_item(CH_VT, 1'b0);
    // stream end with pending escape, empty token, open quote
    send_item(CH_BSLASH, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(CH_DQUOTE, 1'b0);
    send_item(8'h71, 1'b0);
    send_item(8'h00, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_text(input int n);
    int stop_at;
    int len;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_item(8'($urandom_range(0, 255)), 1'b0);
        3: begin
          send_item(CH_BSLASH, 1'b0);
          send_item(pick_escaped(), 1'b0);
        end
        4: begin
          len = $urandom_range(0, 4);
          send_item(CH_DQUOTE, 1'b0);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0) begin
              send_item(CH_BSLASH, 1'b0);
              send_item(pick_escaped(), 1'b0);
            end else begin
              send_item(($urandom_range(0, 1) == 0) ? pick_space() :
                        8'($urandom_range(0, 255)), 1'b0);
            end
          end
          send_item(CH_DQUOTE, 1'b0);
        end
        5, 6: begin
          len = $urandom_range(1, 3);
          repeat (len) send_item(pick_space(), 1'b0);
        end
        7: send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
        default: send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      endcase
    end
    wait_drained();
  endtask

  task automatic test_back_pressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_request = 80;
    send_item(8'h61, 1'b0);
    repeat (30) begin
      send_item(CH_BSLASH, 1'b0);
      send_item(8'h77 + 8'($urandom_range(0, 3)), 1'b0);
    end
    send_item(8'h00, 1'b1);
    wait_drained();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_full_rate();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_text(80);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // result side: random holds per beat, plus one long hold on request
  initial begin : result_sink
    int wait_cycles;
    while (!rst_n) @(posedge clk);
    forever begin
      wait_cycles = rx_idle ? $urandom_range(0, 10) : 0;
      @(negedge clk);
      if (hold_request > 0) begin
        wait_cycles = hold_request;
        hold_request = 0;
      end
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
        out_tready <= 1'b1;
      end
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin : beat_checker
    token_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, 8'h00);
      end else begin
        want = pending_beats.pop_front();
        if (out_tuser[0] !== want.kind)
          report_mismatch("kind", {7'd0, out_tuser[0]}, {7'd0, want.kind});
        if (out_tdata !== want.data)
          report_mismatch("byte", out_tdata, want.data);
        if (out_tuser[1] !== want.by_end)
          report_mismatch("stream end flag", {7'd0, out_tuser[1]}, {7'd0, want.by_end});
        if (out_tlast !== want.is_last)
          report_mismatch("last", {7'd0, out_tlast}, {7'd0, want.is_last});
      end
      beats_checked++;
    end
  end

  always @(posedge clk) begin : stall_watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_text(480);
    test_back_pressure();
    test_full_rate();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("run: %0d input beats (directed, random text, long output stall, full rate)",
             items_sent);
    $display("checked %0d output beats, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
